// File: design/gose_pkg.sv
// Shared types and constants for the glyph outline segment expander.
`timescale 1ns / 1ps

package gose_pkg;

  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned CFG_IDX_W  = 2;

  // Input selector codes
  localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POINT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OUTLINE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY = 2'd3;

  localparam logic signed [COEF_W-1:0] COEF_XX_RST = 32'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_XY_RST = 32'sd0;
  localparam logic signed [COEF_W-1:0] COEF_YX_RST = 32'sd0;
  localparam logic signed [COEF_W-1:0] COEF_YY_RST = 32'sd65536;

  // Segment type field of a command byte
  localparam logic [1:0] SEG_LINE = 2'd2;
  localparam logic [1:0] SEG_QUAD = 2'd3;

  // Output kind flag
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_QUAD = 1'b1;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_POINT,
    OP_OUTLINE
  } gose_op_e;

  // One queued request: packed point (x low, y high) or command byte
  typedef struct packed {
    gose_op_e    op;
    logic [31:0] data;
  } gose_entry_t;

endpackage

// File: design/gose_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gose_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/gose_fifo.sv
// Short request queue between the front and back parts.
`timescale 1ns / 1ps

module gose_fifo #(
  parameter int unsigned DEPTH = gose_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  gose_pkg::gose_entry_t entry_i,
  output logic                  ready_o,
  input  logic                  pop_i,
  output gose_pkg::gose_entry_t entry_o,
  output logic                  valid_o
);
  import gose_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gose_entry_t     slot_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: design/gose_front.sv
// Front part: accepts items, transforms points to pixels, queues requests.
`timescale 1ns / 1ps

module gose_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [gose_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [gose_pkg::COEF_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [gose_pkg::CMD_W-1:0]            in_cmd_i,
  input  logic [gose_pkg::IN_DATA_W-1:0]        in_data_i,
  output logic                                  push_o,
  output gose_pkg::gose_entry_t                 entry_o,
  input  logic                                  q_ready_i
);
  import gose_pkg::*;

  logic signed [COEF_W-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
  logic signed [31:0]       org_x_q, org_y_q;

  logic [7:0]          px, py, in_cb;
  logic signed [31:0]  in_org_x, in_org_y;
  gose_op_e            in_op;
  logic                in_keep;
  logic                adv;
  logic signed [40:0]  prod_xx_d, prod_xy_d, prod_yx_d, prod_yy_d;
  logic signed [42:0]  sum_x_d, sum_y_d;

  // Stage 1: products
  logic                s1_v_q;
  gose_op_e            s1_op_q;
  logic signed [40:0]  s1_pxx_q, s1_pxy_q, s1_pyx_q, s1_pyy_q;
  logic signed [31:0]  s1_org_x_q, s1_org_y_q;
  logic [7:0]          s1_cb_q;
  // Stage 2: sums
  logic                s2_v_q;
  gose_op_e            s2_op_q;
  logic signed [42:0]  s2_sx_q, s2_sy_q;
  logic [7:0]          s2_cb_q;
  // Stage 3: queue entry
  logic                s3_v_q;
  gose_entry_t         s3_entry_q;

  function automatic logic [15:0] round_sat(input logic signed [42:0] s);
    logic signed [42:0] r;
    logic signed [26:0] q;
    r = s + 43'sd32768;
    q = r[42:16];
    if (q > 27'sd32767) begin
      return 16'h7fff;
    end else if (q < -27'sd32768) begin
      return 16'h8000;
    end else begin
      return q[15:0];
    end
  endfunction

  assign in_org_x = in_data_i[31:0];
  assign in_org_y = in_data_i[63:32];
  assign px       = in_data_i[71:64];
  assign py       = in_data_i[79:72];
  assign in_cb    = in_data_i[87:80];

  always_comb begin
    in_keep = 1'b1;
    case (in_cmd_i)
      CMD_BEGIN:   in_op = OP_BEGIN;
      CMD_POINT:   in_op = OP_POINT;
      CMD_OUTLINE: in_op = OP_OUTLINE;
      default: begin
        in_op   = OP_BEGIN;
        in_keep = 1'b0;
      end
    endcase
  end

  assign prod_xx_d = $signed({1'b0, px}) * coef_xx_q;
  assign prod_xy_d = $signed({1'b0, py}) * coef_xy_q;
  assign prod_yx_d = $signed({1'b0, px}) * coef_yx_q;
  assign prod_yy_d = $signed({1'b0, py}) * coef_yy_q;

  assign sum_x_d = 43'(s1_pxx_q) + 43'(s1_pxy_q) + 43'(org_x_q);
  assign sum_y_d = 43'(s1_pyx_q) + 43'(s1_pyy_q) + 43'(org_y_q);

  // The whole pipe holds while the queue refuses the oldest request
  assign adv        = !s3_v_q || q_ready_i;
  assign in_ready_o = adv;
  assign push_o     = s3_v_q && q_ready_i;
  assign entry_o    = s3_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q <= COEF_XX_RST;
      coef_xy_q <= COEF_XY_RST;
      coef_yx_q <= COEF_YX_RST;
      coef_yy_q <= COEF_YY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COEF_XX: coef_xx_q <= cfg_data_i;
        REG_COEF_XY: coef_xy_q <= cfg_data_i;
        REG_COEF_YX: coef_yx_q <= cfg_data_i;
        REG_COEF_YY: coef_yy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      org_x_q <= '0;
      org_y_q <= '0;
    end else if (adv) begin
      s1_v_q <= in_valid_i && in_keep;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      // Origin changes as the begin request leaves stage 1, so points
      // ahead of it have already added the old origin
      if (s1_v_q && s1_op_q == OP_BEGIN) begin
        org_x_q <= s1_org_x_q;
        org_y_q <= s1_org_y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= in_op;
      s1_pxx_q   <= prod_xx_d;
      s1_pxy_q   <= prod_xy_d;
      s1_pyx_q   <= prod_yx_d;
      s1_pyy_q   <= prod_yy_d;
      s1_org_x_q <= in_org_x;
      s1_org_y_q <= in_org_y;
      s1_cb_q    <= in_cb;

      s2_op_q <= s1_op_q;
      s2_sx_q <= sum_x_d;
      s2_sy_q <= sum_y_d;
      s2_cb_q <= s1_cb_q;

      s3_entry_q.op <= s2_op_q;
      case (s2_op_q)
        OP_POINT:   s3_entry_q.data <= {round_sat(s2_sy_q), round_sat(s2_sx_q)};
        OP_OUTLINE: s3_entry_q.data <= {24'd0, s2_cb_q};
        default:    s3_entry_q.data <= '0;
      endcase
    end
  end

endmodule

// File: design/gose_back.sv
// Back part: keeps the point store and pointers, expands commands to segments.
`timescale 1ns / 1ps

module gose_back #(
  parameter int unsigned MAX_POINTS = gose_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  gose_pkg::gose_entry_t               q_entry_i,
  output logic                                q_pop_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [gose_pkg::OUT_DATA_W-1:0]     m_data_o,
  output logic                                m_kind_o,
  output logic                                m_last_o
);
  import gose_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned IDX_W = AW + 1;
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_POINTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_RD3  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]       state_q;
  logic [IDX_W-1:0] wr_q, rd_q, cs_q;
  logic [1:0]       seg_type_q;
  logic [4:0]       cnt_q;
  logic             close_q, closing_q;
  logic [31:0]      p0_q, p1_q, p2_q;
  logic             oob_q;
  logic             m_valid_q, m_kind_q, m_last_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic [IDX_W-1:0] rd_addr, rd_next1, rd_next2;
  logic [31:0]      ram_rdata, rd_point;
  logic             ram_we;
  logic             is_quad, out_free, seg_last;

  function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx,
                                            input logic [1:0] n);
    logic [IDX_W:0] s;
    s = {1'b0, idx} + (IDX_W + 1)'(n);
    if (s > {1'b0, MAX_IDX}) begin
      return MAX_IDX;
    end else begin
      return s[IDX_W-1:0];
    end
  endfunction

  assign rd_next1 = bump(rd_q, 2'd1);
  assign rd_next2 = bump(rd_q, 2'd2);

  always_comb begin
    case (state_q)
      S_RD1:   rd_addr = closing_q ? cs_q : rd_next1;
      S_RD2:   rd_addr = rd_next2;
      default: rd_addr = rd_q;
    endcase
  end

  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign ram_we   = q_pop_o && (q_entry_i.op == OP_POINT) && (wr_q < MAX_IDX);
  assign rd_point = oob_q ? '0 : ram_rdata;
  assign is_quad  = (seg_type_q == SEG_QUAD) && !closing_q;
  assign out_free = !m_valid_q || m_ready_i;
  assign seg_last = closing_q || (cnt_q == 5'd0 && !close_q);

  gose_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q[AW-1:0]),
    .wdata_i (q_entry_i.data),
    .raddr_i (rd_addr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wr_q       <= '0;
      rd_q       <= '0;
      cs_q       <= '0;
      seg_type_q <= '0;
      cnt_q      <= '0;
      close_q    <= 1'b0;
      closing_q  <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            case (q_entry_i.op)
              OP_BEGIN: begin
                wr_q <= '0;
                rd_q <= '0;
                cs_q <= '0;
              end
              OP_POINT: begin
                if (wr_q < MAX_IDX) begin
                  wr_q <= wr_q + 1'b1;
                end
              end
              OP_OUTLINE: begin
                seg_type_q <= q_entry_i.data[1:0];
                cnt_q      <= q_entry_i.data[6:2];
                close_q    <= q_entry_i.data[7];
                if (q_entry_i.data[1:0] == SEG_LINE || q_entry_i.data[1:0] == SEG_QUAD) begin
                  closing_q <= 1'b0;
                  state_q   <= S_RD0;
                end else if (q_entry_i.data[7]) begin
                  closing_q <= 1'b1;
                  state_q   <= S_RD0;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: state_q <= S_RD2;
        S_RD2: state_q <= is_quad ? S_RD3 : S_OUT;
        S_RD3: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            if (closing_q) begin
              rd_q    <= rd_next1;
              cs_q    <= rd_next1;
              state_q <= S_IDLE;
            end else begin
              rd_q <= is_quad ? rd_next2 : rd_next1;
              if (cnt_q != 5'd0) begin
                cnt_q   <= cnt_q - 5'd1;
                state_q <= S_RD0;
              end else if (close_q) begin
                closing_q <= 1'b1;
                state_q   <= S_RD0;
              end else begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Read data arrives in the cycle after its address; addresses past the end read as zero
  always_ff @(posedge clk_i) begin
    oob_q <= (rd_addr >= MAX_IDX);
    case (state_q)
      S_RD1: p0_q <= rd_point;
      S_RD2: p1_q <= rd_point;
      S_RD3: p2_q <= rd_point;
      S_OUT: begin
        if (out_free) begin
          m_data_q <= {(is_quad ? p2_q : 32'd0), p1_q, p0_q};
          m_kind_q <= is_quad ? KIND_QUAD : KIND_LINE;
          m_last_q <= seg_last;
        end
      end
      default: ;
    endcase
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_kind_o  = m_kind_q;
  assign m_last_o  = m_last_q;

  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= MAX_IDX)
    else $error("read pointer beyond store");

  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= MAX_IDX)
    else $error("write pointer beyond store");

  a_cs_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_q <= rd_q)
    else $error("contour start ahead of read pointer");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free && seg_last) |=> (state_q == S_IDLE))
    else $error("sequencer kept running after final segment");

endmodule

// File: design/glyph_outline_segment_expander_core.sv
// Top level: glyph outline expander, front transform pipe, queue and segment back end.
// Input takes one request per cycle until the 4-entry queue and the three front stages
// fill; a point passes stages two and three and the queue before the store write. A
// command leaves the queue, then each line segment takes read states RD0 to RD2 and the
// output state, a quadratic also RD3, set by the single read port of the point store.
// Reset clears pointers, origin and queue, presets coefficients; store contents are kept.
`timescale 1ns / 1ps

module glyph_outline_segment_expander_core #(
  parameter int unsigned MAX_POINTS = gose_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gose_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gose_pkg::COEF_W-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // origin_x [31:0], origin_y [63:32], point_code [79:64], command_byte [87:80]
  input  logic [gose_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd [1:0]
  input  logic [gose_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // x0 [15:0], y0 [31:16], x1 [47:32], y1 [63:48], x2 [79:64], y2 [95:80]
  output logic [gose_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // seg_kind
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import gose_pkg::*;

  logic        push, q_ready, q_valid, pop;
  gose_entry_t push_entry, pop_entry;

  gose_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .push_o     (push),
    .entry_o    (push_entry),
    .q_ready_i  (q_ready)
  );

  gose_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .valid_o (q_valid)
  );

  gose_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (pop_entry),
    .q_pop_o   (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_kind_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule
